[sv/bpvp_pkg.sv]
package bpvp_pkg;

	localparam int PLANES    = 4;
	localparam int PLANE_W   = 2;
	localparam int LANE_W    = 32;
	localparam int PIX_W     = 16;
	localparam int IDX_W     = 4;
	localparam int ROW_W     = PLANES * LANE_W;
	localparam int S_TDATA_W = 8 * PIX_W;
	// plane + word_index + word_data, padded to whole bytes
	localparam int M_FIELD_W = PLANE_W + IDX_W + LANE_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_BURST
	} state_t;

	// top to drain
	typedef struct packed {
		logic start;
	} drain_ctl_t;

	// drain to top
	typedef struct packed {
		logic rd_en;
		logic done;
	} drain_sts_t;

endpackage

[sv/bpvp_ram.sv]
module bpvp_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/bpvp_drain.sv]
module bpvp_drain
	import bpvp_pkg::*;
#(
	parameter int WORDS_PER_VECTOR = 16,
	localparam int AW = (WORDS_PER_VECTOR > 1) ? $clog2(WORDS_PER_VECTOR) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  drain_ctl_t           ctl,
	output drain_sts_t           sts,
	output logic [AW-1:0]        rd_addr,
	input  logic                 row_valid,
	input  logic [ROW_W-1:0]     rd_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	logic               active_q;
	logic [PLANE_W-1:0] plane_q;
	logic [AW-1:0]      widx_q;

	logic               vld_s1;
	logic [PLANE_W-1:0] plane_s1;
	logic [AW-1:0]      widx_s1;
	logic               last_s1;
	logic               rowv_s1;

	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic               m_tlast_q;

	logic               s1_move;
	logic               rd_en;
	logic               row_end;
	logic               issue_last;
	logic [LANE_W-1:0]  lane;

	assign row_end    = (widx_q == AW'(WORDS_PER_VECTOR - 1));
	assign issue_last = row_end && (plane_q == PLANE_W'(PLANES - 1));
	// the ram output register only advances when s1 is empty or the word in s1 can move on
	assign s1_move    = vld_s1 && (!m_tvalid_q || m_tready);
	assign rd_en      = active_q && (!vld_s1 || s1_move);
	assign rd_addr    = widx_q;
	assign lane       = rd_data[plane_s1 * LANE_W +: LANE_W];

	assign sts.rd_en  = rd_en;
	assign sts.done   = rd_en && issue_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			plane_q  <= '0;
			widx_q   <= '0;
		end else if (ctl.start) begin
			active_q <= 1'b1;
			plane_q  <= '0;
			widx_q   <= '0;
		end else if (rd_en) begin
			if (issue_last) begin
				active_q <= 1'b0;
			end else if (row_end) begin
				widx_q  <= '0;
				plane_q <= plane_q + 1'b1;
			end else begin
				widx_q <= widx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rd_en) begin
			vld_s1 <= 1'b1;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			plane_s1 <= plane_q;
			widx_s1  <= widx_q;
			last_s1  <= issue_last;
			rowv_s1  <= row_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_move) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			m_tdata_q <= M_TDATA_W'({(rowv_s1 ? lane : LANE_W'(0)), IDX_W'(widx_s1),
				plane_s1});
			m_tlast_q <= last_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_no_read_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && m_tvalid_q && !m_tready) |-> !rd_en)
		else $error("ram read issued while s1 word is blocked");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.done && !ctl.start) |=> !active_q)
		else $error("drain still active after last read");

endmodule

[sv/bayer_plane_vector_packer.sv]
// start: a word that completes a vector (or an end-of-image word with flush on) starts a
//   burst; each plane word is read from the ram into s1, then registered at the output
// throughput: one input word per cycle while filling, none during a burst; a burst sends
//   4*WORDS_PER_VECTOR words from the single ram read port, one per cycle while m_tready=1
// reset: flush_partial = 1, fill position 0, all row valid bits cleared so every plane
//   word reads as zero; valid bits clear at once, no clearing pass
module bayer_plane_vector_packer
	import bpvp_pkg::*;
#(
	parameter int WORDS_PER_VECTOR = 16,
	parameter int PIXEL_BITS       = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write: flush_partial
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	// slave side
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// top_pixel_0..3, bottom_pixel_0..3, 16 bits each, lowest first
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,     // end_of_image
	// master side
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// plane[1:0], word_index[5:2], word_data[37:6], zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast      // last
);

	localparam int AW = (WORDS_PER_VECTOR > 1) ? $clog2(WORDS_PER_VECTOR) : 1;
	localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((1 << PIXEL_BITS) - 1);

	state_t state_q, state_d;

	logic                        flush_q;
	logic [AW-1:0]               fill_pos_q;
	logic [WORDS_PER_VECTOR-1:0] row_vld_q;
	logic                        eoi_q;

	logic                        s_acc;
	logic                        full_hit;
	logic                        go_burst;
	logic [PIX_W-1:0]            pix [8];
	logic [ROW_W-1:0]            row_wdata;

	logic [AW-1:0]               rd_addr;
	logic [ROW_W-1:0]            rd_data;
	drain_ctl_t                  ctl;
	drain_sts_t                  sts;

	// configuration register, always ready; it only matters at end of image
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			flush_q <= cfg_data;
		end
	end

	// unpack the quad and build one ram row: lane p holds plane p
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pix[i] = s_tdata[i*PIX_W +: PIX_W] & PIX_MASK;
		end
	end

	// plane 0 even-even, 1 even-odd, 2 odd-even, 3 odd-odd; first pixel in low half
	always_comb begin
		for (int p = 0; p < PLANES; p++) begin
			row_wdata[p*LANE_W +: LANE_W] = LANE_W'(pix[(p/2)*4 + (p%2)])
				| (LANE_W'(pix[(p/2)*4 + (p%2) + 2]) << PIXEL_BITS);
		end
	end

	assign s_acc    = s_tvalid && s_tready;
	assign full_hit = (fill_pos_q == AW'(WORDS_PER_VECTOR - 1));
	assign go_burst = s_acc && (full_hit || (s_tlast && flush_q));
	assign ctl.start = go_burst;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (go_burst) begin
					state_d = ST_BURST;
				end
			end
			ST_BURST: begin
				if (sts.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_BURST: s_tready = 1'b0;
			default:  s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// fill position: back to 0 on a burst or on end of image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_pos_q <= '0;
		end else if (s_acc) begin
			if (go_burst || s_tlast) begin
				fill_pos_q <= '0;
			end else begin
				fill_pos_q <= fill_pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eoi_q <= 1'b0;
		end else if (s_acc) begin
			eoi_q <= s_tlast;
		end
	end

	// row valid bits stand in for clearing the ram at reset and at end of image;
	// an image that ends with a burst is cleared once the burst has been read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (s_acc && s_tlast && !go_burst) begin
			row_vld_q <= '0;
		end else if (s_acc) begin
			row_vld_q[fill_pos_q] <= 1'b1;
		end else if (sts.done && eoi_q) begin
			row_vld_q <= '0;
		end
	end

	// one row per fill position, all four planes side by side
	bpvp_ram #(
		.WIDTH (ROW_W),
		.DEPTH (WORDS_PER_VECTOR)
	) u_ram (
		.clk   (clk),
		.we    (s_acc),
		.waddr (fill_pos_q),
		.wdata (row_wdata),
		.re    (sts.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// burst read sequencer and output register
	bpvp_drain #(
		.WORDS_PER_VECTOR (WORDS_PER_VECTOR)
	) u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.rd_addr   (rd_addr),
		.row_valid (row_vld_q[rd_addr]),
		.rd_data   (rd_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	a_full_starts_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && full_hit) |=> (state_q == ST_BURST))
		else $error("full vector did not start a burst");

	a_eoi_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tlast) |=> (fill_pos_q == '0))
		else $error("fill position not reset after end of image");

	a_reads_only_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		sts.rd_en |-> (state_q == ST_BURST))
		else $error("ram read outside a burst");

	a_eoi_clears_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tlast && !go_burst) |=> (row_vld_q == '0))
		else $error("rows still valid after end of image");

endmodule
